FILE: rtl/core/fpa_pkg.sv
// shared types, op codes and the restoring divide step for the q24.8 arithmetic unit
// no dependencies
package fpa_pkg;

	localparam int FRACTION_BITS = 8;
	localparam int DATA_W        = 32;
	// numerator is |a| shifted left by the fraction bits, padded to an even width
	localparam int NUM_W         = DATA_W + FRACTION_BITS;
	localparam int DIV_STAGES    = (NUM_W + 1) / 2;
	localparam int DIV_W         = 2 * DIV_STAGES;

	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_SUB  = 4'd1;
	localparam logic [3:0] OP_MUL  = 4'd2;
	localparam logic [3:0] OP_DIV  = 4'd3;
	localparam logic [3:0] OP_MIN  = 4'd4;
	localparam logic [3:0] OP_MAX  = 4'd5;
	localparam logic [3:0] OP_CMP  = 4'd6;
	localparam logic [3:0] OP_INC  = 4'd7;
	localparam logic [3:0] OP_DEC  = 4'd8;
	localparam logic [3:0] OP_FROM = 4'd9;
	localparam logic [3:0] OP_TOI  = 4'd10;

	typedef struct packed {
		logic [3:0]               req_type;
		logic signed [DATA_W-1:0] operand_a;
		logic signed [DATA_W-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic                     is_equal;
		logic                     is_less;
		logic                     is_greater;
		logic                     divide_by_zero;
	} rsp_t;

	// everything but the divider state, carried alongside it
	typedef struct packed {
		logic [3:0]        op;
		logic [DATA_W-1:0] res;
		logic              eq;
		logic              lt;
		logic              gt;
		logic              dz;
		logic              neg;
	} side_t;

	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [DIV_W-1:0]  nq;   // numerator bits shift out at the top, quotient bits in at the bottom
		logic [DATA_W-1:0] den;
	} div_t;

	function automatic div_t div_step(input div_t d);
		div_t          r;
		logic [DATA_W:0] part;
		logic [DATA_W:0] diff;
		begin
			r    = d;
			part = {d.rem, d.nq[DIV_W-1]};
			diff = part - {1'b0, d.den};
			if (part >= {1'b0, d.den}) begin
				r.rem = diff[DATA_W-1:0];
				r.nq  = {d.nq[DIV_W-2:0], 1'b1};
			end else begin
				r.rem = part[DATA_W-1:0];
				r.nq  = {d.nq[DIV_W-2:0], 1'b0};
			end
			return r;
		end
	endfunction

endpackage

FILE: rtl/core/fpa_prep.sv
// operand stage: multiplier, simple operations, flags and divider set-up
// depends on fpa_pkg
module fpa_prep import fpa_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  req_t  req_s1,
	output side_t side_s2,
	output div_t  div_s2
);

	logic signed [2*DATA_W-1:0] prod;
	logic [DATA_W-1:0]          a_u;
	logic [DATA_W-1:0]          b_u;
	logic [DATA_W-1:0]          abs_a;
	logic [DATA_W-1:0]          abs_b;
	logic                       lt;
	logic                       gt;
	logic                       eq;
	side_t                      side_d;
	div_t                       div_d;

	assign a_u   = req_s1.operand_a;
	assign b_u   = req_s1.operand_b;
	assign prod  = req_s1.operand_a * req_s1.operand_b;
	assign abs_a = a_u[DATA_W-1] ? (~a_u + 1'b1) : a_u;
	assign abs_b = b_u[DATA_W-1] ? (~b_u + 1'b1) : b_u;
	assign lt    = req_s1.operand_a < req_s1.operand_b;
	assign gt    = req_s1.operand_a > req_s1.operand_b;
	assign eq    = a_u == b_u;

	always_comb begin
		side_d     = '0;
		side_d.op  = req_s1.req_type;
		side_d.neg = a_u[DATA_W-1] ^ b_u[DATA_W-1];
		case (req_s1.req_type)
			OP_ADD:  side_d.res = a_u + b_u;
			OP_SUB:  side_d.res = a_u - b_u;
			OP_MUL:  side_d.res = prod[FRACTION_BITS +: DATA_W];
			OP_DIV:  side_d.dz  = (b_u == '0);
			OP_MIN:  side_d.res = lt ? a_u : b_u;
			OP_MAX:  side_d.res = gt ? a_u : b_u;
			OP_CMP: begin
				side_d.eq = eq;
				side_d.lt = lt;
				side_d.gt = gt;
			end
			OP_INC:  side_d.res = a_u + 1'b1;
			OP_DEC:  side_d.res = a_u - 1'b1;
			OP_FROM: side_d.res = a_u << FRACTION_BITS;
			OP_TOI:  side_d.res = DATA_W'(req_s1.operand_a >>> FRACTION_BITS);
			default: side_d.res = '0;
		endcase
		div_d     = '0;
		div_d.nq  = {{(DIV_W-DATA_W){1'b0}}, abs_a} << FRACTION_BITS;
		div_d.den = abs_b;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_d;
			div_s2  <= div_d;
		end
	end

endmodule

FILE: rtl/core/fpa_div_stage.sv
// one divider stage: two restoring steps, side data passed along
// depends on fpa_pkg
module fpa_div_stage import fpa_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  side_t side_in,
	input  div_t  div_in,
	output side_t side_s1,
	output div_t  div_s1
);

	div_t step1;
	div_t step2;

	assign step1 = div_step(div_in);
	assign step2 = div_step(step1);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			div_s1  <= step2;
		end
	end

endmodule

FILE: rtl/core/fpa_post.sv
// output stage: applies the quotient sign and picks the final result
// depends on fpa_pkg
module fpa_post import fpa_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  side_t side_in,
	input  div_t  div_in,
	output rsp_t  rsp_s1
);

	logic [DATA_W-1:0] quo;
	rsp_t              rsp_d;

	// only the low bits of the quotient survive the wrap
	assign quo = side_in.neg ? (~div_in.nq[DATA_W-1:0] + 1'b1) : div_in.nq[DATA_W-1:0];

	always_comb begin
		rsp_d.is_equal       = side_in.eq;
		rsp_d.is_less        = side_in.lt;
		rsp_d.is_greater     = side_in.gt;
		rsp_d.divide_by_zero = side_in.dz;
		if (side_in.op == OP_DIV) begin
			rsp_d.result_value = side_in.dz ? '0 : quo;
		end else begin
			rsp_d.result_value = side_in.res;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_s1 <= rsp_d;
		end
	end

endmodule

FILE: rtl/core/fixed_point_q24_8_alu.sv
// channel | dir | handshake          | payload
// req     | in  | req_valid/req_stall | req_t: req_type, operand_a, operand_b
// rsp     | out | rsp_valid/rsp_stall | rsp_t: result_value, compare and divide flags
//
// one request a cycle unless stalled; every result passes the request register, the operand
// stage, the divider stages, which resolve two quotient bits a stage, and the output stage.
// all operations take the same path, so results keep request order.
// each stage holds while the one after it is full and stalled; empty stages close up.
// arst_n clears only the valid bits.
// top level of the q24.8 fixed-point unit; depends on fpa_pkg, fpa_prep, fpa_div_stage, fpa_post
module fixed_point_q24_8_alu import fpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int NSTG = DIV_STAGES + 3;

	logic [NSTG-1:0] vld_q;
	logic [NSTG:0]   en;
	logic [NSTG-1:0] vin;
	req_t            req_s1;
	side_t           side_p [0:DIV_STAGES];
	div_t            div_p  [0:DIV_STAGES];

	assign en[NSTG]         = !rsp_stall;
	assign vin[0]           = req_valid;
	assign vin[NSTG-1:1]    = vld_q[NSTG-2:0];

	for (genvar i = 0; i < NSTG; i++) begin : g_ctl
		assign en[i] = !vld_q[i] || en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NSTG; i++) begin
				if (en[i]) begin
					vld_q[i] <= vin[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			req_s1 <= req;
		end
	end

	fpa_prep u_prep (
		.clk     (clk),
		.en      (en[1]),
		.req_s1  (req_s1),
		.side_s2 (side_p[0]),
		.div_s2  (div_p[0])
	);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		fpa_div_stage u_stage (
			.clk     (clk),
			.en      (en[k+2]),
			.side_in (side_p[k]),
			.div_in  (div_p[k]),
			.side_s1 (side_p[k+1]),
			.div_s1  (div_p[k+1])
		);
	end

	fpa_post u_post (
		.clk     (clk),
		.en      (en[NSTG-1]),
		.side_in (side_p[DIV_STAGES]),
		.div_in  (div_p[DIV_STAGES]),
		.rsp_s1  (rsp)
	);

	assign req_stall = !en[0];
	assign rsp_valid = vld_q[NSTG-1];

endmodule

FILE: rtl/core/fpa_checker.sv
// port-level checks for the q24.8 fixed-point unit, bound to the top level
// depends on fpa_pkg and fixed_point_q24_8_alu
module fpa_checker import fpa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a held result stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// a stalled request stays put
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("request changed while stalled");

	// with nothing waiting at the output the pipe must take a transfer
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("request stalled with empty output");

	a_cmp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0({rsp.is_equal, rsp.is_less, rsp.is_greater, rsp.divide_by_zero}))
		else $error("conflicting result flags");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.divide_by_zero |-> rsp.result_value == '0)
		else $error("divide by zero with non-zero result");

endmodule

bind fixed_point_q24_8_alu fpa_checker u_fpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
